// ===== design/aes_cbc_pkg.sv =====
// Shared types, register indexes and round functions of the AES ECB/CBC unit.
// Used by the key expansion sequencer, the top level and the port checker.
// No dependencies.
package aes_cbc_pkg;

    localparam int KEY_WORDS_MAX = 60;
    localparam int KEY_ROWS      = KEY_WORDS_MAX / 4;
    localparam int WIDX_W        = $clog2(KEY_WORDS_MAX);
    localparam int ROW_W         = $clog2(KEY_ROWS);

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY_0    = 3'd0;
    localparam logic [2:0] REG_KEY_1    = 3'd1;
    localparam logic [2:0] REG_KEY_2    = 3'd2;
    localparam logic [2:0] REG_KEY_3    = 3'd3;
    localparam logic [2:0] REG_KEY_SIZE = 3'd4;
    localparam logic [2:0] REG_MODE     = 3'd5;
    localparam logic [2:0] REG_IV_HIGH  = 3'd6;
    localparam logic [2:0] REG_IV_LOW   = 3'd7;

    // Key size codes.
    localparam logic [1:0] KSIZE_128 = 2'd0;
    localparam logic [1:0] KSIZE_192 = 2'd1;

    // One word of the expanded schedule on its way into the key stores.
    typedef struct packed {
        logic              vld;
        logic [ROW_W-1:0]  row;
        logic [1:0]        lane;
        logic [31:0]       word;
        logic [31:0]       inv_word;
    } t_kwr;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3, all;
        a0  = w[31:24];
        a1  = w[23:16];
        a2  = w[15:8];
        a3  = w[7:0];
        all = a0 ^ a1 ^ a2 ^ a3;
        return {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] x2, x4, x8;
        for (int i = 0; i < 4; i++) begin
            a[i]   = w[31-8*i -: 8];
            x2     = xtime(a[i]);
            x4     = xtime(x2);
            x8     = xtime(x4);
            m9[i]  = x8 ^ a[i];
            m11[i] = x8 ^ x2 ^ a[i];
            m13[i] = x8 ^ x4 ^ a[i];
            m14[i] = x8 ^ x4 ^ x2;
        end
        return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                m9[0]  ^ m14[1] ^ m11[2] ^ m13[3],
                m13[0] ^ m9[1]  ^ m14[2] ^ m11[3],
                m11[0] ^ m13[1] ^ m9[2]  ^ m14[3]};
    endfunction

    // State byte n sits at bits [127-8n -: 8]; column c is bytes 4c to 4c+3.
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [127:0] t, r;
        for (int n = 0; n < 16; n++) t[127-8*n -: 8] = SBOX[s[127-8*n -: 8]];
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                r[127-8*(i+4*c) -: 8] = t[127-8*(i+4*((c+i)%4)) -: 8];
        if (!last)
            for (int c = 0; c < 4; c++) r[127-32*c -: 32] = mix_col(r[127-32*c -: 32]);
        return r;
    endfunction

    function automatic logic [127:0] dec_round(input logic [127:0] s, input logic last);
        logic [127:0] t, r;
        for (int n = 0; n < 16; n++) t[127-8*n -: 8] = INV_SBOX[s[127-8*n -: 8]];
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                r[127-8*(i+4*c) -: 8] = t[127-8*(i+4*((c+4-i)%4)) -: 8];
        if (!last)
            for (int c = 0; c < 4; c++) r[127-32*c -: 32] = inv_mix_col(r[127-32*c -: 32]);
        return r;
    endfunction

endpackage

// ===== design/aes_cbc_kexp.sv =====
// Key expansion sequencer: one schedule word per cycle, plus its inverse-cipher form.
// Depends on aes_cbc_pkg.
module aes_cbc_kexp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [255:0]        i_key,
    input  logic [1:0]          i_key_size,
    output logic                o_busy,
    output aes_cbc_pkg::t_kwr   o_wr
);
    import aes_cbc_pkg::*;

    logic              r_busy;
    logic [WIDX_W-1:0] r_i;
    logic [2:0]        r_j;
    logic [7:0]        r_rc;
    logic [31:0]       r_win [8];
    logic              r_wv;
    logic [WIDX_W-1:0] r_wi;
    logic [31:0]       r_ww;
    logic              r_wmid;

    logic [2:0]        nk_m1;
    logic [WIDX_W-1:0] total_m1;
    logic [WIDX_W-1:0] mid_end;
    logic [31:0]       back;
    logic [31:0]       t;
    logic [31:0]       n_word;
    logic              rot_step;

    always_comb begin
        case (i_key_size)
            KSIZE_128: begin
                nk_m1    = 3'd3;
                total_m1 = WIDX_W'(43);
                back     = r_win[3];
            end
            KSIZE_192: begin
                nk_m1    = 3'd5;
                total_m1 = WIDX_W'(51);
                back     = r_win[5];
            end
            default: begin
                nk_m1    = 3'd7;
                total_m1 = WIDX_W'(59);
                back     = r_win[7];
            end
        endcase
        mid_end  = total_m1 - WIDX_W'(3);
        rot_step = (r_j == 3'd0);
        if (rot_step)
            t = sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rc, 24'h0};
        else if (nk_m1 == 3'd7 && r_j == 3'd4)
            t = sub_word(r_win[0]);
        else
            t = r_win[0];
        // The first nk words are the key itself, highest register bits first.
        if (r_i <= WIDX_W'(nk_m1))
            n_word = i_key[{~r_i[2:0], 5'b0} +: 32];
        else
            n_word = back ^ t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
            r_j    <= '0;
            r_rc   <= 8'h01;
            r_wv   <= 1'b0;
        end else begin
            r_wv <= r_busy;
            if (r_busy) begin
                r_i <= r_i + WIDX_W'(1);
                r_j <= (r_j == nk_m1) ? 3'd0 : r_j + 3'd1;
                if (rot_step && r_i > WIDX_W'(nk_m1))
                    r_rc <= xtime(r_rc);
                if (r_i == total_m1)
                    r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_win[0] <= n_word;
            for (int k = 1; k < 8; k++) r_win[k] <= r_win[k-1];
            r_wi   <= r_i;
            r_ww   <= n_word;
            r_wmid <= (r_i >= WIDX_W'(4)) && (r_i < mid_end);
        end
    end

    assign o_busy        = r_busy | r_wv;
    assign o_wr.vld      = r_wv;
    assign o_wr.row      = r_wi[WIDX_W-1:2];
    assign o_wr.lane     = r_wi[1:0];
    assign o_wr.word     = r_ww;
    assign o_wr.inv_word = r_wmid ? inv_mix_col(r_ww) : r_ww;

endmodule

// ===== design/aes_block_cipher_cbc_unit.sv =====
// Top level of the AES-128/192/256 ECB/CBC block cipher unit.
// Depends on aes_cbc_pkg and aes_cbc_kexp.
//
// One 128-bit block per item, one round per cycle from a shared round unit
// fed by two round key memories (cipher keys and equivalent-inverse keys,
// one 128-bit row per round, each row registered ahead of its round). The
// next block can be accepted only after the result of the last one has moved
// into the output register, at the earliest in the cycle in which that result
// is first offered; the round count and output back-pressure set the rate.
// After reset and after every write of a key register or of key_size the
// schedule is rebuilt, one word a cycle, and no item is accepted meanwhile. A
// finished result waits in an output register while the next block is taken.
module aes_block_cipher_cbc_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [127:0]   i_s_axis_tdata,   // block_high [63:0], block_low [127:64]
    input  logic           i_s_axis_tuser,   // first_block
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output logic [127:0]   o_m_axis_tdata,   // result_high [63:0], result_low [127:64]
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [63:0]    i_cfg_data
);
    import aes_cbc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADD  = 2'd1;
    localparam logic [1:0] S_RND  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [63:0]  r_key [4];
    logic [1:0]   r_key_size;
    logic [1:0]   r_mode;
    logic [127:0] r_iv;
    logic [127:0] r_chain;

    logic [1:0]   r_st;
    logic [3:0]   r_cnt;
    logic         r_out_vld;
    logic [127:0] r_out;
    logic [127:0] r_blk;
    logic [127:0] r_cv;
    logic [127:0] r_cin;
    logic [127:0] r_key_q;

    logic [127:0] r_rk_mem  [KEY_ROWS];
    logic [127:0] r_ikey_mem [KEY_ROWS];

    logic         kexp_busy;
    t_kwr         kwr;
    logic         cfg_acc;
    logic         s_acc;
    logic         dec;
    logic         cbc;
    logic [3:0]   nr;
    logic [3:0]   next_k;
    logic [3:0]   rd_k;
    logic [ROW_W-1:0] rd_row;
    logic         rd_en;
    logic         last;
    logic [127:0] blk_in;
    logic [127:0] cv;
    logic [127:0] n_blk;
    logic [127:0] rnd_out;
    logic [127:0] result;
    logic         out_move;

    aes_cbc_kexp u_kexp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (cfg_acc && i_cfg_index <= REG_KEY_SIZE),
        .i_key      ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_key_size (r_key_size),
        .o_busy     (kexp_busy),
        .o_wr       (kwr)
    );

    assign o_cfg_ready     = 1'b1;
    assign cfg_acc         = i_cfg_valid;
    assign o_s_axis_tready = (r_st == S_IDLE) && !kexp_busy;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign dec             = r_mode[0];
    assign cbc             = r_mode[1];

    always_comb begin
        case (r_key_size)
            KSIZE_128: nr = 4'd10;
            KSIZE_192: nr = 4'd12;
            default:   nr = 4'd14;
        endcase
        case (r_st)
            S_IDLE:  next_k = 4'd0;
            S_ADD:   next_k = 4'd1;
            default: next_k = r_cnt + 4'd1;
        endcase
        // Decryption walks the inverse key rows from round Nr down to zero.
        rd_k    = dec ? nr - next_k : next_k;
        rd_row  = rd_k[ROW_W-1:0];
        last    = (r_cnt == nr);
        rd_en   = s_acc || (r_st == S_ADD) || (r_st == S_RND && !last);
        blk_in  = {i_s_axis_tdata[63:0], i_s_axis_tdata[127:64]};
        cv      = (cbc && i_s_axis_tuser) ? r_iv : r_chain;
        n_blk   = (cbc && !dec) ? blk_in ^ cv : blk_in;
        rnd_out = (dec ? dec_round(r_blk, last) : enc_round(r_blk, last)) ^ r_key_q;
        result  = (cbc && dec) ? r_blk ^ r_cv : r_blk;
        out_move = (r_st == S_DONE) && (!r_out_vld || i_m_axis_tready);
    end

    // Key stores: written a word lane at a time, read a whole round key per cycle while rd_en is high.
    always_ff @(posedge i_clk) begin
        if (kwr.vld) begin
            r_rk_mem[kwr.row][{~kwr.lane, 5'b0} +: 32]   <= kwr.word;
            r_ikey_mem[kwr.row][{~kwr.lane, 5'b0} +: 32] <= kwr.inv_word;
        end
        if (rd_en)
            r_key_q <= dec ? r_ikey_mem[rd_row] : r_rk_mem[rd_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
            r_key_size <= KSIZE_128;
            r_mode     <= '0;
            r_iv       <= '0;
            r_chain    <= '0;
            r_st       <= S_IDLE;
            r_cnt      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (cfg_acc) begin
                case (i_cfg_index)
                    REG_KEY_0:    r_key[0]   <= i_cfg_data;
                    REG_KEY_1:    r_key[1]   <= i_cfg_data;
                    REG_KEY_2:    r_key[2]   <= i_cfg_data;
                    REG_KEY_3:    r_key[3]   <= i_cfg_data;
                    REG_KEY_SIZE: r_key_size <= i_cfg_data[1:0];
                    REG_MODE:     r_mode     <= i_cfg_data[1:0];
                    REG_IV_HIGH:  r_iv[127:64] <= i_cfg_data;
                    REG_IV_LOW:   r_iv[63:0]   <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_st)
                S_IDLE: begin
                    if (s_acc) begin
                        r_cnt <= 4'd0;
                        r_st  <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_cnt <= 4'd1;
                    r_st  <= S_RND;
                end
                S_RND: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (last)
                        r_st <= S_DONE;
                end
                S_DONE: begin
                    if (out_move) begin
                        if (cbc)
                            r_chain <= dec ? r_cin : r_blk;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
            if (out_move)
                r_out_vld <= 1'b1;
            else if (i_m_axis_tready)
                r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                if (s_acc) begin
                    r_blk <= n_blk;
                    r_cv  <= cv;
                    r_cin <= blk_in;
                end
            end
            S_ADD:   r_blk <= r_blk ^ r_key_q;
            S_RND:   r_blk <= rnd_out;
            default: ;
        endcase
        if (out_move)
            r_out <= result;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out[63:0], r_out[127:64]};

endmodule

// ===== design/aes_cbc_port_check.sv =====
// Port-level checker of the AES ECB/CBC unit, bound to its top level.
// Depends on aes_cbc_pkg and aes_block_cipher_cbc_unit.
module aes_cbc_port_check (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    input  logic           o_s_axis_tready,
    input  logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    input  logic [127:0]   o_m_axis_tdata,
    input  logic           i_cfg_valid,
    input  logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index
);
    import aes_cbc_pkg::*;

    logic s_acc;
    logic key_wr;

    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign key_wr = i_cfg_valid && o_cfg_ready && i_cfg_index <= REG_KEY_SIZE;

    // Blocks are processed one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("input accepted again right after an item");

    // A key change rebuilds the schedule before any block is taken.
    a_key_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_wr |=> !o_s_axis_tready)
        else $error("input ready during key expansion");

    // A result cannot appear in the cycle right after its block was accepted.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !$rose(o_m_axis_tvalid))
        else $error("result offered too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed or dropped");

endmodule

bind aes_block_cipher_cbc_unit aes_cbc_port_check u_port_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .i_cfg_valid     (i_cfg_valid),
    .o_cfg_ready     (o_cfg_ready),
    .i_cfg_index     (i_cfg_index)
);
